/* hw/rtl/lfo_pkg.sv */
package lfo_pkg;

    localparam int PHASE_BITS     = 16;
    localparam int SINE_ADDR_BITS = 10;
    localparam int SINE_SIZE      = 1 << SINE_ADDR_BITS;
    localparam int SUM_W          = ((PHASE_BITS > 16) ? PHASE_BITS : 16) + 1;
    localparam int SH_DN          = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
    localparam int SH_UP          = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
    localparam int WIDE_W         = PHASE_BITS + 16;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint ONE_Q30    = 64'sd1 << 30;
    localparam longint COS_DIV [12] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef enum logic [2:0] {
        WAVE_TRIANGLE = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_RAMP     = 3'd2,
        WAVE_SAW      = 3'd3,
        WAVE_SINE     = 3'd4
    } wave_sel_t;

    typedef enum logic [1:0] {
        CFG_RISE = 2'd0,
        CFG_FALL = 2'd1,
        CFG_WAVE = 2'd2,
        CFG_AMP  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        func;
        logic        eoc;
        logic [15:0] pos;
    } tick_t;

    typedef logic [SINE_SIZE-1:0][15:0] sine_rom_t;

    // Phase to a 16-bit cycle fraction
    function automatic logic [15:0] phase_to_16(input logic [PHASE_BITS-1:0] p);
        logic [WIDE_W-1:0] tmp;
        tmp = WIDE_W'(p);
        return 16'((tmp >> SH_DN) << SH_UP);
    endfunction

    function automatic logic [PHASE_BITS-1:0] phase_from_16(input logic [15:0] v);
        logic [WIDE_W-1:0] tmp;
        tmp = WIDE_W'(v);
        return PHASE_BITS'((tmp << SH_DN) >> SH_UP);
    endfunction

    // Taylor series cosine in Q30 on [0, pi/2]
    function automatic longint cos_q30(input longint theta);
        longint t2;
        longint term;
        longint acc;
        t2   = (theta * theta) >>> 30;
        term = ONE_Q30;
        acc  = ONE_Q30;
        for (int n = 0; n < 12; n++)
        begin
            term = ((term * t2) >>> 30) / COS_DIV[n];
            if (n % 2 == 1)
                acc = acc + term;
            else
                acc = acc - term;
        end
        return acc;
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        longint    m;
        longint    c;
        longint    v;
        longint    outv;
        logic      neg;
        for (int i = 0; i < SINE_SIZE; i++)
        begin
            m   = (i <= SINE_SIZE / 2) ? longint'(i) : longint'(SINE_SIZE - i);
            neg = 1'b0;
            if (m > SINE_SIZE / 4)
            begin
                m   = SINE_SIZE / 2 - m;
                neg = 1'b1;
            end
            c = cos_q30((TWO_PI_Q30 * m) >>> SINE_ADDR_BITS);
            if (neg)
                c = -c;
            v = c + ONE_Q30;
            if (v < 0)
                v = 0;
            outv = (v + (64'sd1 << 14)) >>> 15;
            if (outv > 65535)
                outv = 65535;
            rom[i] = 16'(outv);
        end
        return rom;
    endfunction

endpackage

/* hw/rtl/lfo_sine_rom.sv */
module lfo_sine_rom (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [lfo_pkg::SINE_ADDR_BITS-1:0] addr,
    output logic [15:0]                        data_reg
);
    import lfo_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine();

    always_ff @(posedge clk)
    begin
        if (rd_en)
            data_reg <= SINE_ROM[addr];
    end

endmodule

/* hw/rtl/lfo_phase_acc.sv */
module lfo_phase_acc (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               func,
    input  logic [15:0]                        phase_value,
    input  logic [15:0]                        rise_inc,
    input  logic [15:0]                        fall_inc,
    output lfo_pkg::tick_t                     tick_reg,
    output logic [lfo_pkg::SINE_ADDR_BITS-1:0] rom_addr
);
    import lfo_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [15:0]           inc;
    logic [SUM_W-1:0]      sum;
    logic                  eoc;
    logic [15:0]           pos;

    always_comb
    begin
        // Rise step in the first half cycle, fall step in the second
        inc = phase_reg[PHASE_BITS-1] ? fall_inc : rise_inc;
        sum = SUM_W'(phase_reg) + SUM_W'(inc);
        if (func == FUNC_LOAD)
        begin
            phase_next = phase_from_16(phase_value);
            eoc        = 1'b0;
        end
        else
        begin
            phase_next = sum[PHASE_BITS-1:0];
            eoc        = |sum[SUM_W-1:PHASE_BITS];
        end
        pos      = phase_to_16(phase_next);
        rom_addr = pos[15 -: SINE_ADDR_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (accept)
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            tick_reg <= '{func: func, eoc: eoc, pos: pos};
    end

endmodule

/* hw/rtl/lfo_shaper.sv */
module lfo_shaper (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  lfo_pkg::tick_t tick,
    input  logic [15:0]    sine_data,
    input  logic [2:0]     wave_sel,
    input  logic [16:0]    amplitude,
    output logic [15:0]    result
);
    import lfo_pkg::*;

    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic [17:0] tri_raw;
    logic [16:0] saw_raw;
    logic [15:0] wave;
    logic [16:0] amp_sat;
    logic [32:0] prod;
    logic [15:0] scaled;

    always_comb
    begin
        tri_raw = tick.pos[15] ? ((18'h10000 - 18'(tick.pos)) << 1) : (18'(tick.pos) << 1);
        saw_raw = 17'h10000 - 17'(tick.pos);
        case (wave_sel)
            WAVE_TRIANGLE: wave = (tri_raw[17:16] != 2'b00) ? 16'hFFFF : tri_raw[15:0];
            WAVE_SQUARE:   wave = (tick.pos > 16'h8000) ? 16'hFFFF : 16'h0000;
            WAVE_RAMP:     wave = tick.pos;
            WAVE_SAW:      wave = saw_raw[16] ? 16'hFFFF : saw_raw[15:0];
            WAVE_SINE:     wave = sine_data;
            default:       wave = 16'h0000;
        endcase
        amp_sat = (amplitude > 17'h10000) ? 17'h10000 : amplitude;
        prod    = 33'(wave) * 33'(amp_sat);
        scaled  = prod[31:16];
        // Load transactions report the last tick's value
        result    = (tick.func == FUNC_LOAD) ? held_reg : scaled;
        held_next = (advance && tick.func == FUNC_TICK) ? scaled : held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else
            held_reg <= held_next;
    end

endmodule

/* hw/rtl/lfo_waveform_generator_top.sv */
// Channel   Dir  Signals                    Contents (lowest bit first)
// s_*       in   tvalid tready tdata tuser  tdata: phase_value[15:0]; tuser: func
// m_*       out  tvalid tready tdata tlast  tdata: wave_value[15:0]; tlast: end_of_cycle
// cfg_*     in   we addr wdata              addr: register index; wdata[16:0]
//
// One transaction per cycle sustained while m_tready holds; the phase register
// update loop sets this rate. From input to output register a transaction
// passes the middle stage (sine ROM read), then shape and multiply.
// Reset clears phase, held value and valid flags, and loads register defaults.
// A stalled output holds the pipeline; the input side keeps taking
// transactions while the middle stage or output register has room.
module lfo_waveform_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // phase_value[15:0]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // wave_value[15:0]
    output logic        m_tlast,   // end_of_cycle
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [16:0] cfg_wdata
);
    import lfo_pkg::*;

    logic [15:0] rise_reg;
    logic [15:0] fall_reg;
    logic [2:0]  wave_reg;
    logic [16:0] amp_reg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [15:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic        out_free;
    logic        accept;
    logic        s1_adv;

    tick_t                     tick;
    logic [SINE_ADDR_BITS-1:0] rom_addr;
    logic [15:0]               sine_data;
    logic [15:0]               result;

    always_comb
    begin
        out_free      = !m_tvalid_reg || m_tready;
        s_tready      = !s1_valid_reg || out_free;
        accept        = s_tvalid && s_tready;
        s1_adv        = s1_valid_reg && out_free;
        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        m_tvalid_next = s1_adv ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg <= 16'd65;
            fall_reg <= 16'd65;
            wave_reg <= WAVE_TRIANGLE;
            amp_reg  <= 17'd4095;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_RISE: rise_reg <= cfg_wdata[15:0];
                CFG_FALL: fall_reg <= cfg_wdata[15:0];
                CFG_WAVE: wave_reg <= cfg_wdata[2:0];
                CFG_AMP:  amp_reg  <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            m_tdata_reg <= result;
            m_tlast_reg <= tick.eoc;
        end
    end

    lfo_phase_acc u_phase_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (s_tuser),
        .phase_value (s_tdata),
        .rise_inc    (rise_reg),
        .fall_inc    (fall_reg),
        .tick_reg    (tick),
        .rom_addr    (rom_addr)
    );

    lfo_sine_rom u_sine_rom (
        .clk      (clk),
        .rd_en    (accept),
        .addr     (rom_addr),
        .data_reg (sine_data)
    );

    lfo_shaper u_shaper (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_adv),
        .tick      (tick),
        .sine_data (sine_data),
        .wave_sel  (wave_reg),
        .amplitude (amp_reg),
        .result    (result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("middle stage dropped a transaction while stalled");

    a_accept_full_needs_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> out_free)
        else $error("accepted into a full middle stage");

    a_load_no_eoc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && tick.func == FUNC_LOAD) |=> !m_tlast)
        else $error("load transaction flagged end of cycle");

endmodule
